// ----- rtl/core/dmbg_pkg.sv -----
// Shared types and constants of the debounced mode button gate.
// Field widths, operation codes and event verdict codes; no dependencies.
package dmbg_pkg;

  localparam int unsigned TickW  = 32;
  localparam int unsigned MaskW  = 3;
  localparam int unsigned IndexW = 3;
  localparam int unsigned CountW = 32;

  localparam logic [TickW-1:0] StableTicksReset = 32'd100;

  // Input beat operation, carried in tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_EVENT  = 2'd1,
    OP_INIT   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Button event kinds; the unused code acts as an other event
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_OTHER   = 2'd2,
    EV_SPARE   = 2'd3
  } event_kind_t;

  // Event verdicts
  typedef enum logic [1:0] {
    VERDICT_DROP   = 2'd0,
    VERDICT_NOTIFY = 2'd1,
    VERDICT_ACCEPT = 2'd2,
    VERDICT_UNUSED = 2'd3
  } verdict_t;

endpackage

// ----- rtl/core/debounced_mode_button_gate.sv -----
// Debounced mode button gate: top level with the whole single-pass datapath.
// Depends on dmbg_pkg for field widths, operation and verdict codes.
//
// Usage
//   Input stream (s_axis_*): one beat per item. tuser carries the operation
//   (sample, button event, init). tdata carries the item fields.
//   Output stream (m_axis_*): exactly one result beat per input beat, in order.
//   Config channel (cfg_*): writes stable_ticks; always ready. Write it only
//   while no result is outstanding.
// Timing
//   The result is registered: a beat accepted at an edge shows its result at
//   the output from that edge. Throughput is one item per cycle while the
//   receiver keeps m_axis_tready high; the state update and the result are
//   computed in one pass of short logic into the state and output registers.
// Reset
//   rst (synchronous, active high) clears the gate state, opens the gate,
//   sets stable_ticks to 100 and empties the output register.
// Stall
//   The output register holds its beat while m_axis_tready is low; the
//   input stays ready as long as that register is empty or being drained
//   in the same cycle, so a stalled receiver stops intake after one beat.
module debounced_mode_button_gate
  import dmbg_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic        clk,
  input  logic        rst,
  // Config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,        // stable_ticks
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] selector_high, [1] ignition_on, [4:2] held_mask, [36:5] timestamp,
  // [39:37] button_index, [41:40] event_kind, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,    // [1:0] op
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] cancel_mask, [4:3] verdict, [5] input_allowed,
  // [37:6] blocked_count, [39:38] zero
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned NB = NUM_BUTTONS;

  // Unpacked input fields
  logic              in_sel;
  logic              in_ign;
  logic [MaskW-1:0]  in_held;
  logic [TickW-1:0]  in_now;
  logic [IndexW-1:0] in_button;
  event_kind_t       in_kind;
  op_t               in_op;

  assign in_sel    = s_axis_tdata[0];
  assign in_ign    = s_axis_tdata[1];
  assign in_held   = s_axis_tdata[4:2];
  assign in_now    = s_axis_tdata[36:5];
  assign in_button = s_axis_tdata[39:37];
  assign in_kind   = event_kind_t'(s_axis_tdata[41:40]);
  assign in_op     = op_t'(s_axis_tuser);

  // State registers
  logic [TickW-1:0]  stable_ticks;
  logic              seeded;
  logic              candidate_level;
  logic              stable_level;
  logic [TickW-1:0]  change_time;
  logic              allowed_flag;
  logic [NB-1:0]     pressed_bits;
  logic [NB-1:0]     inhibited_bits;
  logic [NB-1:0]     accepted_bits;
  logic [CountW-1:0] blocked_cnt;

  logic              seeded_next;
  logic              candidate_level_next;
  logic              stable_level_next;
  logic [TickW-1:0]  change_time_next;
  logic              allowed_flag_next;
  logic [NB-1:0]     pressed_bits_next;
  logic [NB-1:0]     inhibited_bits_next;
  logic [NB-1:0]     accepted_bits_next;
  logic [CountW-1:0] blocked_cnt_next;

  logic [MaskW-1:0]  cancel_next;
  verdict_t          verdict_next;

  logic              in_fire;
  logic              out_fire;

  assign cfg_ready     = 1'b1;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Width-adapted helpers
  logic [7:0]        held_wide;
  logic [NB-1:0]     held_nb;
  logic [7:0]        accepted_wide;
  logic [NB-1:0]     button_bit;
  logic              button_valid;
  logic [TickW-1:0]  elapsed;
  logic              cand_seed;
  logic [TickW-1:0]  time_seed;
  logic              stable_seed;
  logic              cand_upd;
  logic [TickW-1:0]  time_upd;
  logic              stable_upd;
  logic              allowed_upd;
  logic              release_ok;

  assign held_wide     = 8'(in_held);
  assign held_nb       = held_wide[NB-1:0];
  assign accepted_wide = 8'(accepted_bits);
  assign button_bit    = NB'(1) << in_button;
  assign button_valid  = {1'b0, in_button} < 4'(NB);

  // Debounce path: seed on the first sample, restart timer on a level change
  always_comb begin
    cand_seed   = seeded ? candidate_level : in_sel;
    stable_seed = seeded ? stable_level : in_sel;
    time_seed   = seeded ? change_time : in_now;
    cand_upd    = in_sel;
    time_upd    = (cand_seed != in_sel) ? in_now : time_seed;
    elapsed     = in_now - time_upd;
    stable_upd  = (elapsed >= stable_ticks) ? cand_upd : stable_seed;
    allowed_upd = !in_ign || stable_upd;
    release_ok  = |(accepted_bits & button_bit) && allowed_flag &&
                  !(|(inhibited_bits & button_bit));
  end

  // Next state and result for one item
  always_comb begin
    seeded_next          = seeded;
    candidate_level_next = candidate_level;
    stable_level_next    = stable_level;
    change_time_next     = change_time;
    allowed_flag_next    = allowed_flag;
    pressed_bits_next    = pressed_bits;
    inhibited_bits_next  = inhibited_bits;
    accepted_bits_next   = accepted_bits;
    blocked_cnt_next     = blocked_cnt;
    cancel_next          = '0;
    verdict_next         = VERDICT_DROP;

    unique case (in_op)
      OP_SAMPLE: begin
        seeded_next          = 1'b1;
        candidate_level_next = cand_upd;
        change_time_next     = time_upd;
        stable_level_next    = stable_upd;
        allowed_flag_next    = allowed_upd;
        if (!allowed_upd) begin
          cancel_next         = accepted_wide[MaskW-1:0];
          inhibited_bits_next = inhibited_bits | held_nb | pressed_bits;
          accepted_bits_next  = '0;
        end
      end
      OP_EVENT: begin
        if (button_valid) begin
          if (in_kind == EV_PRESS) begin
            if (!(|(pressed_bits & button_bit))) begin
              pressed_bits_next = pressed_bits | button_bit;
              if (!allowed_flag) begin
                inhibited_bits_next = inhibited_bits | button_bit;
                blocked_cnt_next    = blocked_cnt + CountW'(1);
                verdict_next        = VERDICT_NOTIFY;
              end else if (!(|(inhibited_bits & button_bit))) begin
                accepted_bits_next = accepted_bits | button_bit;
                verdict_next       = VERDICT_ACCEPT;
              end
            end
          end else begin
            if (release_ok) begin
              verdict_next = VERDICT_ACCEPT;
            end
            if (in_kind == EV_RELEASE) begin
              pressed_bits_next   = pressed_bits & ~button_bit;
              inhibited_bits_next = inhibited_bits & ~button_bit;
              accepted_bits_next  = accepted_bits & ~button_bit;
            end
          end
        end
      end
      OP_INIT: begin
        seeded_next          = 1'b0;
        candidate_level_next = 1'b0;
        stable_level_next    = 1'b0;
        change_time_next     = '0;
        allowed_flag_next    = 1'b1;
        pressed_bits_next    = held_nb;
        inhibited_bits_next  = held_nb;
        accepted_bits_next   = '0;
        blocked_cnt_next     = '0;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Hold state; advance on an accepted beat; take config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_ticks    <= StableTicksReset;
      seeded          <= 1'b0;
      candidate_level <= 1'b0;
      stable_level    <= 1'b0;
      change_time     <= '0;
      allowed_flag    <= 1'b1;
      pressed_bits    <= '0;
      inhibited_bits  <= '0;
      accepted_bits   <= '0;
      blocked_cnt     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        stable_ticks <= cfg_data;
      end
      if (in_fire) begin
        seeded          <= seeded_next;
        candidate_level <= candidate_level_next;
        stable_level    <= stable_level_next;
        change_time     <= change_time_next;
        allowed_flag    <= allowed_flag_next;
        pressed_bits    <= pressed_bits_next;
        inhibited_bits  <= inhibited_bits_next;
        accepted_bits   <= accepted_bits_next;
        blocked_cnt     <= blocked_cnt_next;
      end
    end
  end

  // Output register: load on accept, drop valid when drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_fire) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {2'b00, blocked_cnt_next, allowed_flag_next,
                       verdict_next, cancel_next};
    end
  end

`ifndef SYNTHESIS
  // An accepted button is never also inhibited
  a_acc_not_inhibited: assert property (@(posedge clk) disable iff (rst)
    (accepted_bits & inhibited_bits) == '0)
    else $error("accepted button is also inhibited");

  // An accepted button is always pressed
  a_acc_pressed: assert property (@(posedge clk) disable iff (rst)
    (accepted_bits & ~pressed_bits) == '0)
    else $error("accepted button is not pressed");

  // A closed gate leaves no accepted buttons
  a_closed_no_acc: assert property (@(posedge clk) disable iff (rst)
    !allowed_flag |-> accepted_bits == '0)
    else $error("accepted buttons while gate closed");

  // Blocked count holds, steps by one, or clears on init
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (blocked_cnt == $past(blocked_cnt) ||
              blocked_cnt == $past(blocked_cnt) + CountW'(1) ||
              blocked_cnt == '0))
    else $error("blocked count jumped");
`endif

endmodule

// ----- tb/dmbg_checker.sv -----
// Result checker for the debounced mode button gate testbench.
// Watches the config, input and result channels, predicts each result beat and
// compares it; depends on dmbg_pkg for widths, operation and verdict codes.
module dmbg_checker
  import dmbg_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        run_end,
  output int          errors,
  output int          outstanding,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MaskW-1:0] BtnMask = MaskW'((1 << NUM_BUTTONS) - 1);

  typedef struct packed {
    logic [MaskW-1:0]  cancel;
    verdict_t          verdict;
    logic              allowed;
    logic [CountW-1:0] count;
  } gate_result_t;

  // Mirror of the gate state and its one register
  logic [TickW-1:0]  hold_ticks;
  logic              sel_seeded;
  logic              sel_candidate;
  logic              sel_stable;
  logic [TickW-1:0]  sel_change_t;
  logic              gate_open;
  logic [MaskW-1:0]  btn_pressed;
  logic [MaskW-1:0]  btn_inhibited;
  logic [MaskW-1:0]  btn_accepted;
  logic [CountW-1:0] blocked_total;
  logic              end_seen;

  gate_result_t gate_results_q[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    checked     = 0;
    end_seen    = 1'b0;
  end

  // Return the gate to its reset state, seeding the held buttons
  task automatic clear_gate(input logic [MaskW-1:0] held);
    sel_seeded    = 1'b0;
    sel_candidate = 1'b0;
    sel_stable    = 1'b0;
    sel_change_t  = '0;
    gate_open     = 1'b1;
    btn_pressed   = held & BtnMask;
    btn_inhibited = held & BtnMask;
    btn_accepted  = '0;
    blocked_total = '0;
  endtask

  // Advance the mirror by one input beat and work out its result
  task automatic step_gate(input op_t op, input logic [47:0] d, output gate_result_t r);
    logic              sel;
    logic              ign;
    logic [MaskW-1:0]  held;
    logic [TickW-1:0]  now;
    logic [IndexW-1:0] idx;
    event_kind_t       kind;
    logic [MaskW-1:0]  bit_m;
    logic              ok;
    sel  = d[0];
    ign  = d[1];
    held = d[4:2];
    now  = d[36:5];
    idx  = d[39:37];
    kind = event_kind_t'(d[41:40]);
    r.cancel  = '0;
    r.verdict = VERDICT_DROP;
    case (op)
      OP_SAMPLE: begin
        if (!sel_seeded) begin
          sel_candidate = sel;
          sel_stable    = sel;
          sel_change_t  = now;
          sel_seeded    = 1'b1;
        end
        if (sel_candidate != sel) begin
          sel_candidate = sel;
          sel_change_t  = now;
        end
        if (TickW'(now - sel_change_t) >= hold_ticks) sel_stable = sel_candidate;
        gate_open = !ign || sel_stable;
        if (!gate_open) begin
          r.cancel      = btn_accepted;
          btn_inhibited = btn_inhibited | ((held | btn_pressed) & BtnMask);
          btn_accepted  = '0;
        end
      end
      OP_EVENT: begin
        if (idx < NUM_BUTTONS) begin
          bit_m = '0;
          bit_m[idx] = 1'b1;
          if (kind == EV_PRESS) begin
            if ((btn_pressed & bit_m) == '0) begin
              btn_pressed = btn_pressed | bit_m;
              if (!gate_open) begin
                btn_inhibited = btn_inhibited | bit_m;
                blocked_total = blocked_total + 1'b1;
                r.verdict     = VERDICT_NOTIFY;
              end else if ((btn_inhibited & bit_m) == '0) begin
                btn_accepted = btn_accepted | bit_m;
                r.verdict    = VERDICT_ACCEPT;
              end
            end
          end else begin
            // Release, repeat and the spare kind all pass only accepted buttons
            ok = ((btn_accepted & bit_m) != '0) && gate_open &&
                 ((btn_inhibited & bit_m) == '0);
            if (kind == EV_RELEASE) begin
              btn_pressed   = btn_pressed & ~bit_m;
              btn_inhibited = btn_inhibited & ~bit_m;
              btn_accepted  = btn_accepted & ~bit_m;
            end
            if (ok) r.verdict = VERDICT_ACCEPT;
          end
        end
      end
      OP_INIT: clear_gate(held);
      default: ;
    endcase
    r.allowed = gate_open;
    r.count   = blocked_total;
  endtask

  task automatic report_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Compare result beats, predict input beats, then take config writes
  always @(posedge clk) begin
    gate_result_t want;
    gate_result_t got;
    if (rst) begin
      clear_gate('0);
      hold_ticks = StableTicksReset;
      gate_results_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cancel  = m_axis_tdata[2:0];
        got.verdict = verdict_t'(m_axis_tdata[4:3]);
        got.allowed = m_axis_tdata[5];
        got.count   = m_axis_tdata[37:6];
        checked++;
        if (gate_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none actual %0h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = gate_results_q.pop_front();
          report_field("cancel_mask", 32'(want.cancel), 32'(got.cancel));
          report_field("verdict", 32'(want.verdict), 32'(got.verdict));
          report_field("input_allowed", 32'(want.allowed), 32'(got.allowed));
          report_field("blocked_count", want.count, got.count);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_gate(op_t'(s_axis_tuser), s_axis_tdata, want);
        gate_results_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) hold_ticks = cfg_data;
      if (run_end && !end_seen) begin
        end_seen = 1'b1;
        if (gate_results_q.size() != 0) begin
          $display("%0t: results missing at end, expected %0d more actual 0",
                   $time, gate_results_q.size());
          errors++;
        end
      end
    end
    outstanding = gate_results_q.size();
  end

endmodule

// ----- tb/tb_debounced_mode_button_gate.sv -----
// Top of the debounced mode button gate testbench: clock, reset and stimulus.
// Instantiates the gate and dmbg_checker, which predicts and compares results.
module tb_debounced_mode_button_gate;
  import dmbg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseItems = 265;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [39:0] m_axis_tdata;
  logic        run_end = 1'b0;

  int errors;
  int outstanding;
  int checked;
  int items_sent = 0;
  int stall_left = 0;
  int settings_used = 1;
  bit idle_on = 1'b1;
  logic [31:0] tick_now = '0;
  logic        sel_now = 1'b0;

  debounced_mode_button_gate #(.NUM_BUTTONS(3)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dmbg_checker #(.NUM_BUTTONS(3)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .run_end       (run_end),
    .errors        (errors),
    .outstanding   (outstanding),
    .checked       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3_000_000;
    $display("[debounced_mode_button_gate] ERROR");
    $finish;
  end

  // Receiver: stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [47:0] pack_item(logic sel, logic ign, logic [2:0] held,
                                            logic [31:0] ts, logic [2:0] idx,
                                            event_kind_t kind);
    return {6'b0, kind, idx, ts, held, ign, sel};
  endfunction

  // Offer one input beat, optionally after an idle burst, and hold it until taken
  task automatic push_item(input op_t op, input logic [47:0] data);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_sample(input logic sel, input logic ign, input logic [2:0] held,
                             input logic [31:0] ts);
    push_item(OP_SAMPLE, pack_item(sel, ign, held, ts, 3'($urandom), EV_OTHER));
  endtask

  task automatic send_event(input logic [2:0] idx, input event_kind_t kind);
    push_item(OP_EVENT, pack_item(1'($urandom), 1'($urandom), 3'($urandom), $urandom,
                                  idx, kind));
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_stable_ticks(input logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly samples and button events on a moving tick count, with some noise
  task automatic run_random(input int count);
    int          pick;
    int          step_pick;
    logic        sel;
    logic        ign;
    logic [2:0]  held;
    logic [31:0] ts;
    logic [2:0]  idx;
    event_kind_t kind;
    op_t         op;
    for (int n = 0; n < count; n++) begin
      sel  = 1'($urandom);
      ign  = 1'($urandom);
      held = 3'($urandom);
      ts   = $urandom;
      idx  = 3'($urandom);
      kind = event_kind_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        op = OP_SAMPLE;
        step_pick = $urandom_range(0, 99);
        if (step_pick < 70) tick_now = tick_now + $urandom_range(0, 40);
        else if (step_pick < 95) tick_now = tick_now + $urandom_range(0, 400);
        else tick_now = $urandom;
        if ($urandom_range(0, 3) == 0) sel_now = ~sel_now;
        sel = sel_now;
        ign = ($urandom_range(0, 4) != 0);
        ts  = tick_now;
      end else if (pick < 88) begin
        op = OP_EVENT;
        idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
        step_pick = $urandom_range(0, 99);
        if (step_pick < 40) kind = EV_PRESS;
        else if (step_pick < 75) kind = EV_RELEASE;
        else if (step_pick < 90) kind = EV_OTHER;
        else kind = EV_SPARE;
      end else if (pick < 95) begin
        op = OP_INIT;
      end else begin
        op = OP_NONE;
      end
      push_item(op, pack_item(sel, ign, held, ts, idx, kind));
    end
  endtask

  initial begin
    logic [31:0] tick_settings[6];
    tick_settings[0] = 32'd0;
    tick_settings[1] = 32'd1;
    tick_settings[2] = 32'hFFFF_FFFF;
    tick_settings[3] = 32'($urandom_range(2, 30));
    tick_settings[4] = $urandom;
    tick_settings[5] = 32'd100;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: open gate before any sample, out-of-range buttons, spare kind
    send_event(3'd0, EV_PRESS);
    send_event(3'd0, EV_OTHER);
    send_event(3'd0, EV_RELEASE);
    send_event(3'd7, EV_PRESS);
    send_event(3'd3, EV_PRESS);
    send_event(3'd1, EV_SPARE);
    send_event(3'd2, EV_PRESS);
    // First sample seeds a low selector and closes the gate, cancelling button 2
    send_sample(1'b0, 1'b1, 3'd0, 32'hFFFF_FFF0);
    send_event(3'd1, EV_PRESS);
    send_event(3'd1, EV_PRESS);
    // Selector rises; the debounce interval spans the tick wrap
    send_sample(1'b1, 1'b1, 3'd0, 32'hFFFF_FFF8);
    send_sample(1'b1, 1'b1, 3'd0, 32'h0000_0050);
    send_sample(1'b1, 1'b1, 3'd0, 32'h0000_005C);
    send_event(3'd0, EV_PRESS);
    send_event(3'd2, EV_PRESS);
    send_event(3'd2, EV_RELEASE);
    send_event(3'd1, EV_OTHER);
    send_event(3'd1, EV_RELEASE);
    // Ignition off opens the gate whatever the selector says
    send_sample(1'b0, 1'b0, 3'd7, 32'hFFFF_FFFF);
    push_item(OP_NONE, pack_item(1'b1, 1'b1, 3'd7, 32'hFFFF_FFFF, 3'd7, EV_SPARE));
    // Init seeds held buttons as pressed and inhibited
    push_item(OP_INIT, pack_item(1'b0, 1'b0, 3'd7, 32'd0, 3'd0, EV_PRESS));
    send_event(3'd0, EV_PRESS);
    send_event(3'd0, EV_RELEASE);
    send_event(3'd0, EV_PRESS);
    send_sample(1'b0, 1'b1, 3'd5, 32'd0);

    // Random phases, each under its own debounce interval
    for (int p = 0; p < 6; p++) begin
      write_stable_ticks(tick_settings[p]);
      if (p == 5) idle_on = 1'b0;
      run_random(PhaseItems / 2);
      if (p == 2) drain_results();
      run_random(PhaseItems - PhaseItems / 2);
    end

    drain_results();
    repeat (4) @(posedge clk);
    run_end <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Sent %0d items and checked %0d results under %0d debounce settings,",
             items_sent, checked, settings_used);
    $display("including intervals of 0, 1 and all ones with wrapped tick counts.");
    if (errors == 0) begin
      $display("[debounced_mode_button_gate] OK");
    end else begin
      $display("[debounced_mode_button_gate] ERROR");
    end
    $finish;
  end

endmodule
